// ===== rtl/core/fupc_pkg.sv =====
`default_nettype none

package fupc_pkg;

  localparam int unsigned HdrLen = 16;

  localparam logic [3:0] STATUS_OK          = 4'd0;
  localparam logic [3:0] STATUS_SHORT       = 4'd1;
  localparam logic [3:0] STATUS_MAGIC       = 4'd2;
  localparam logic [3:0] STATUS_VERSION     = 4'd3;
  localparam logic [3:0] STATUS_FLAGS       = 4'd4;
  localparam logic [3:0] STATUS_ATTACHMENTS = 4'd5;
  localparam logic [3:0] STATUS_TOO_LARGE   = 4'd6;
  localparam logic [3:0] STATUS_LENGTH      = 4'd7;
  localparam logic [3:0] STATUS_UTF8        = 4'd8;

  localparam logic [0:0] REG_EXPECTED_VERSION = 1'd0;
  localparam logic [0:0] REG_MAX_TEXT_BYTES   = 1'd1;

  localparam logic [7:0] MAGIC_0 = 8'h43;
  localparam logic [7:0] MAGIC_1 = 8'h48;
  localparam logic [7:0] MAGIC_2 = 8'h54;
  localparam logic [7:0] MAGIC_3 = 8'h31;

  typedef logic [0:0] cfg_index_t;

  typedef struct packed {
    logic       is_verdict;
    logic [7:0] text_byte;
    logic [3:0] status;
    logic       end_of_run;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/fupc_if.sv =====
`default_nettype none

interface fupc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface fupc_out_if;
  logic       valid;
  logic       ready;
  logic       is_verdict;
  logic [7:0] text_byte;
  logic [3:0] status;
  logic       end_of_run;

  modport source (output valid, output is_verdict, output text_byte, output status,
                  output end_of_run, input ready);
  modport sink (input valid, input is_verdict, input text_byte, input status,
                input end_of_run, output ready);
endinterface

interface fupc_cfg_if;
  logic                      valid;
  logic                      ready;
  fupc_pkg::cfg_index_t      index;
  logic [31:0]               wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/framed_utf8_payload_checker.sv =====
// Framed UTF-8 payload checker.
// in_i: one payload byte per item, final_byte set on the last byte. The first
//   16 bytes are the header (magic, version, flags, text length, attachments,
//   reserved); every later byte is text.
// out_o: each text byte comes back as a text result; the final byte also
//   yields one verdict result (is_verdict and end_of_run set, status code),
//   after its text result when it lies past the header.
// cfg_i: register 0 expected_version, register 1 max_text_bytes. Always ready;
//   write only while no payload is in flight.
// The first result of an item reaches out_o the cycle after it is
//   accepted when the result queue is empty; later results wait their turn.
//   One item per cycle while each item gives at most one result and the
//   receiver takes results; a final byte adds one verdict, drained one result
//   per cycle while the receiver is ready, from the four-entry result queue.
// in_i.ready is high while the queue has room for two results, so a stalled
//   receiver stops input once the queue fills; nothing is dropped.
// Reset clears the queue and all per-payload state and restores the
//   register defaults (version 1, max text 65536 bytes).
`default_nettype none

module framed_utf8_payload_checker (
  input  wire       clk_i,
  input  wire       rst_ni,
  fupc_in_if.sink   in_i,
  fupc_out_if.source out_o,
  fupc_cfg_if.sink  cfg_i
);

  logic [15:0] exp_version_q;
  logic [31:0] max_text_q;

  logic [31:0] count_q, count_d;
  logic [15:0] version_q, version_d;
  logic [31:0] length_q, length_d;
  logic        magic_bad_q, magic_bad_d;
  logic        flags_bad_q, flags_bad_d;
  logic        attach_bad_q, attach_bad_d;
  logic [1:0]  pend_q, pend_d;
  logic [1:0]  seq_q, seq_d;
  logic [20:0] cp_q, cp_d;
  logic        utf8_bad_q, utf8_bad_d;

  fupc_pkg::result_t fifo_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] fill_q;

  logic       accept, pop, in_hdr;
  logic [3:0] hidx;
  logic [7:0] b;
  logic [3:0] status;
  logic [1:0] push_n;
  logic [20:0] cp_next;
  fupc_pkg::result_t text_res, verdict_res, first_res;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (fill_q <= 3'd2);
  assign accept      = in_i.valid && in_i.ready;
  assign pop         = out_o.valid && out_o.ready;
  assign b           = in_i.data_byte;
  assign in_hdr      = (count_q[31:4] == 28'd0);
  assign hidx        = count_q[3:0];
  assign cp_next     = {cp_q[14:0], b[5:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_version_q <= 16'd1;
      max_text_q    <= 32'd65536;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        fupc_pkg::REG_EXPECTED_VERSION: exp_version_q <= cfg_i.wdata[15:0];
        fupc_pkg::REG_MAX_TEXT_BYTES:   max_text_q    <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    count_d      = count_q + {31'd0, (count_q != 32'hFFFF_FFFF)};
    version_d    = version_q;
    length_d     = length_q;
    magic_bad_d  = magic_bad_q;
    flags_bad_d  = flags_bad_q;
    attach_bad_d = attach_bad_q;
    pend_d       = pend_q;
    seq_d        = seq_q;
    cp_d         = cp_q;
    utf8_bad_d   = utf8_bad_q;

    if (in_hdr) begin
      case (hidx)
        4'd0:  magic_bad_d = magic_bad_q || (b != fupc_pkg::MAGIC_0);
        4'd1:  magic_bad_d = magic_bad_q || (b != fupc_pkg::MAGIC_1);
        4'd2:  magic_bad_d = magic_bad_q || (b != fupc_pkg::MAGIC_2);
        4'd3:  magic_bad_d = magic_bad_q || (b != fupc_pkg::MAGIC_3);
        4'd4:  version_d[7:0]   = b;
        4'd5:  version_d[15:8]  = b;
        4'd8:  length_d[7:0]    = b;
        4'd9:  length_d[15:8]   = b;
        4'd10: length_d[23:16]  = b;
        4'd11: length_d[31:24]  = b;
        4'd12, 4'd13: attach_bad_d = attach_bad_q || (b != 8'd0);
        default: flags_bad_d = flags_bad_q || (b != 8'd0);
      endcase
    end else if (!utf8_bad_q) begin
      if (pend_q == 2'd0) begin
        if (b[7] == 1'b0) begin
          pend_d = 2'd0;
        end else if (b[7:5] == 3'b110) begin
          if (b[4:0] == 5'd0) begin
            utf8_bad_d = 1'b1;
          end else begin
            seq_d  = 2'd1;
            pend_d = 2'd1;
            cp_d   = {16'd0, b[4:0]};
          end
        end else if (b[7:4] == 4'b1110) begin
          seq_d  = 2'd2;
          pend_d = 2'd2;
          cp_d   = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
          seq_d  = 2'd3;
          pend_d = 2'd3;
          cp_d   = {18'd0, b[2:0]};
        end else begin
          utf8_bad_d = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        utf8_bad_d = 1'b1;
      end else begin
        cp_d   = cp_next;
        pend_d = pend_q - 2'd1;
        if (pend_q == 2'd1) begin
          if ((seq_q == 2'd1 && cp_next < 21'h80) ||
              (seq_q == 2'd2 && cp_next < 21'h800) ||
              (seq_q == 2'd3 && cp_next < 21'h10000) ||
              (cp_next > 21'h10FFFF) ||
              (cp_next >= 21'hD800 && cp_next <= 21'hDFFF)) begin
            utf8_bad_d = 1'b1;
          end
        end
      end
    end

    if (count_d < 32'(fupc_pkg::HdrLen))       status = fupc_pkg::STATUS_SHORT;
    else if (magic_bad_d)                      status = fupc_pkg::STATUS_MAGIC;
    else if (version_d != exp_version_q)       status = fupc_pkg::STATUS_VERSION;
    else if (flags_bad_d)                      status = fupc_pkg::STATUS_FLAGS;
    else if (attach_bad_d)                     status = fupc_pkg::STATUS_ATTACHMENTS;
    else if (length_d > max_text_q)            status = fupc_pkg::STATUS_TOO_LARGE;
    else if ({1'b0, count_d} != ({1'b0, length_d} + 33'(fupc_pkg::HdrLen)))
                                               status = fupc_pkg::STATUS_LENGTH;
    else if (utf8_bad_d || (pend_d != 2'd0))   status = fupc_pkg::STATUS_UTF8;
    else                                       status = fupc_pkg::STATUS_OK;

    text_res    = '{is_verdict: 1'b0, text_byte: b, status: fupc_pkg::STATUS_OK,
                    end_of_run: 1'b0};
    verdict_res = '{is_verdict: 1'b1, text_byte: 8'd0, status: status, end_of_run: 1'b1};
    first_res   = in_hdr ? verdict_res : text_res;
    push_n      = accept ? ({1'b0, !in_hdr} + {1'b0, in_i.final_byte}) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= 32'd0;
      version_q    <= 16'd0;
      length_q     <= 32'd0;
      magic_bad_q  <= 1'b0;
      flags_bad_q  <= 1'b0;
      attach_bad_q <= 1'b0;
      pend_q       <= 2'd0;
      seq_q        <= 2'd0;
      cp_q         <= 21'd0;
      utf8_bad_q   <= 1'b0;
    end else if (accept) begin
      if (in_i.final_byte) begin
        count_q      <= 32'd0;
        version_q    <= 16'd0;
        length_q     <= 32'd0;
        magic_bad_q  <= 1'b0;
        flags_bad_q  <= 1'b0;
        attach_bad_q <= 1'b0;
        pend_q       <= 2'd0;
        seq_q        <= 2'd0;
        cp_q         <= 21'd0;
        utf8_bad_q   <= 1'b0;
      end else begin
        count_q      <= count_d;
        version_q    <= version_d;
        length_q     <= length_d;
        magic_bad_q  <= magic_bad_d;
        flags_bad_q  <= flags_bad_d;
        attach_bad_q <= attach_bad_d;
        pend_q       <= pend_d;
        seq_q        <= seq_d;
        cp_q         <= cp_d;
        utf8_bad_q   <= utf8_bad_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wp_q] <= first_res;
    end
    if (push_n == 2'd2) begin
      fifo_q[wp_q + 2'd1] <= verdict_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= 2'd0;
      rp_q   <= 2'd0;
      fill_q <= 3'd0;
    end else begin
      wp_q   <= wp_q + push_n;
      rp_q   <= rp_q + {1'b0, pop};
      fill_q <= fill_q + {1'b0, push_n} - {2'd0, pop};
    end
  end

  assign out_o.valid      = (fill_q != 3'd0);
  assign out_o.is_verdict = fifo_q[rp_q].is_verdict;
  assign out_o.text_byte  = fifo_q[rp_q].text_byte;
  assign out_o.status     = fifo_q[rp_q].status;
  assign out_o.end_of_run = fifo_q[rp_q].end_of_run;

endmodule

`default_nettype wire

// ===== rtl/core/fupc_checker.sv =====
`default_nettype none

module fupc_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_ready_i,
  input wire       in_final_i,
  input wire       out_valid_i,
  input wire       out_ready_i,
  input wire       out_is_verdict_i,
  input wire [7:0] out_text_byte_i,
  input wire [3:0] out_status_i,
  input wire       out_end_of_run_i
);

  a_verdict_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_is_verdict_i |-> out_end_of_run_i && (out_text_byte_i == 8'd0) &&
      (out_status_i <= fupc_pkg::STATUS_UTF8))
    else $error("verdict result malformed");

  a_text_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_is_verdict_i |-> !out_end_of_run_i &&
      (out_status_i == fupc_pkg::STATUS_OK))
    else $error("text result carries verdict fields");

  a_final_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_final_i |=> out_valid_i)
    else $error("final item produced no result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_is_verdict_i) &&
      $stable(out_text_byte_i) && $stable(out_status_i) && $stable(out_end_of_run_i))
    else $error("stalled result changed");

endmodule

bind framed_utf8_payload_checker fupc_checker u_fupc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_final_i      (in_i.final_byte),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_is_verdict_i(out_o.is_verdict),
  .out_text_byte_i (out_o.text_byte),
  .out_status_i    (out_o.status),
  .out_end_of_run_i(out_o.end_of_run)
);

`default_nettype wire
